### hdl/swsd_pkg.sv
// Shared types and defaults for the sliding-window silence detector.
// No dependencies; imported by every module of the block except swsd_ram.
`default_nettype none
package swsd_pkg;

    localparam int WINDOW_MAX_DEF  = 1024;
    localparam int SAMPLE_BITS_DEF = 20;
    localparam int WLEN_BITS       = 11;
    localparam int THR_BITS        = 20;
    localparam int IN_BITS         = 20;
    localparam int POS_BITS        = 32;

    localparam logic REG_WLEN = 1'b0;
    localparam logic REG_THR  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXP_RD,
        ST_EXP_CHK,
        ST_BACK_RD,
        ST_BACK_CHK,
        ST_PUSH,
        ST_FRONT_RD,
        ST_FINISH
    } swsd_state_t;

    typedef struct packed {
        logic latch;
        logic drop_head;
        logic back_rd;
        logic drop_tail;
        logic push;
        logic finish;
        logic sel;
    } swsd_cmd_t;

    typedef struct packed {
        logic cnt_zero;
        logic expire_hit;
        logic back_hit;
        logic out_busy;
    } swsd_status_t;

endpackage
`default_nettype wire

### hdl/swsd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module swsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                   clk,
    input  wire logic                                   we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                       rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

### hdl/swsd_ctrl.sv
// Sequencer for one item: expire, pop back and push on each deque, then judge.
// Depends on swsd_pkg.
`default_nettype none
module swsd_ctrl
    import swsd_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_ready,
    input  wire swsd_status_t status,
    output swsd_cmd_t         cmd,
    output swsd_state_t       state
);
    swsd_state_t state_reg, state_next;
    logic        sel_reg, sel_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            sel_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        sel_next   = sel_reg;
        cmd        = '0;
        cmd.sel    = sel_reg;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.latch  = 1'b1;
                    sel_next   = 1'b0;
                    state_next = ST_EXP_RD;
                end
            end
            ST_EXP_RD:
            begin
                state_next = status.cnt_zero ? ST_BACK_RD : ST_EXP_CHK;
            end
            ST_EXP_CHK:
            begin
                if (status.expire_hit)
                begin
                    cmd.drop_head = 1'b1;
                    state_next    = ST_EXP_RD;
                end
                else
                begin
                    state_next = ST_BACK_RD;
                end
            end
            ST_BACK_RD:
            begin
                cmd.back_rd = 1'b1;
                state_next  = status.cnt_zero ? ST_PUSH : ST_BACK_CHK;
            end
            ST_BACK_CHK:
            begin
                if (status.back_hit)
                begin
                    cmd.drop_tail = 1'b1;
                    state_next    = ST_BACK_RD;
                end
                else
                begin
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH:
            begin
                cmd.push = 1'b1;
                if (!sel_reg)
                begin
                    sel_next   = 1'b1;
                    state_next = ST_EXP_RD;
                end
                else
                begin
                    state_next = ST_FRONT_RD;
                end
            end
            ST_FRONT_RD:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!status.out_busy)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign state = state_reg;
endmodule
`default_nettype wire

### hdl/swsd_dp.sv
// Datapath: sample counter, two circular deques in RAM, and the result register.
// Depends on swsd_pkg and swsd_ram.
`default_nettype none
module swsd_dp
    import swsd_pkg::*;
#(
    parameter int WINDOW_MAX  = WINDOW_MAX_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire swsd_cmd_t             cmd,
    input  wire logic [IN_BITS-1:0]    sample,
    input  wire logic                  last_sample,
    input  wire logic [WLEN_BITS-1:0]  window_length,
    input  wire logic [THR_BITS-1:0]   threshold,
    input  wire logic                  out_ready,
    output swsd_status_t               status,
    output logic                       out_valid,
    output logic [POS_BITS-1:0]        start_position
);
    localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int CW = $clog2(WINDOW_MAX + 1);
    localparam int EW = SAMPLE_BITS + POS_BITS;
    localparam logic [31:0] WMAX32 = 32'(WINDOW_MAX);

    logic [SAMPLE_BITS-1:0] v_reg;
    logic                   last_reg;
    logic [POS_BITS-1:0]    pos_reg;
    logic [CW-1:0]          len_reg;
    logic [AW-1:0]          head_reg  [2];
    logic [CW-1:0]          count_reg [2];
    logic                   out_valid_reg;
    logic [POS_BITS-1:0]    start_reg;

    logic [31:0]            samp32, wl32, len32, back32, push32, inc32;
    logic [POS_BITS-1:0]    pos_inc;
    logic [AW-1:0]          hd, back_addr, push_addr, head_inc;
    logic [CW-1:0]          ct;
    logic [AW-1:0]          raddr_min, raddr_max;
    logic [EW-1:0]          rd_min, rd_max, rd_cur, wdata;
    logic [SAMPLE_BITS-1:0] cur_val, lo, hi, spread;
    logic [POS_BITS-1:0]    cur_pos;
    logic                   hit;

    assign samp32  = {{(32-IN_BITS){1'b0}}, sample};
    assign wl32    = {{(32-WLEN_BITS){1'b0}}, window_length};
    assign len32   = (wl32 == 32'd0) ? 32'd1 : ((wl32 > WMAX32) ? WMAX32 : wl32);
    assign pos_inc = (pos_reg == '1) ? pos_reg : pos_reg + 1'b1;

    assign hd     = head_reg[cmd.sel];
    assign ct     = count_reg[cmd.sel];
    assign back32 = 32'(hd) + 32'(ct) - 32'd1;
    assign push32 = 32'(hd) + 32'(ct);
    assign inc32  = 32'(hd) + 32'd1;
    assign back_addr = (back32 >= WMAX32) ? AW'(back32 - WMAX32) : AW'(back32);
    assign push_addr = (push32 >= WMAX32) ? AW'(push32 - WMAX32) : AW'(push32);
    assign head_inc  = (inc32 >= WMAX32) ? '0 : AW'(inc32);

    assign raddr_min = (cmd.back_rd && !cmd.sel) ? back_addr : head_reg[0];
    assign raddr_max = (cmd.back_rd && cmd.sel)  ? back_addr : head_reg[1];
    assign wdata     = {pos_reg, v_reg};

    swsd_ram #(.WIDTH(EW), .DEPTH(WINDOW_MAX)) u_min_ram (
        .clk   (clk),
        .we    (cmd.push && !cmd.sel),
        .waddr (push_addr),
        .wdata (wdata),
        .raddr (raddr_min),
        .rdata (rd_min)
    );

    swsd_ram #(.WIDTH(EW), .DEPTH(WINDOW_MAX)) u_max_ram (
        .clk   (clk),
        .we    (cmd.push && cmd.sel),
        .waddr (push_addr),
        .wdata (wdata),
        .raddr (raddr_max),
        .rdata (rd_max)
    );

    assign rd_cur  = cmd.sel ? rd_max : rd_min;
    assign cur_val = rd_cur[SAMPLE_BITS-1:0];
    assign cur_pos = rd_cur[EW-1:SAMPLE_BITS];

    assign lo     = rd_min[SAMPLE_BITS-1:0];
    assign hi     = rd_max[SAMPLE_BITS-1:0];
    assign spread = (hi >= lo) ? hi - lo : '0;
    assign hit    = (pos_reg >= 32'(len_reg))
                 && ({{(32-SAMPLE_BITS){1'b0}}, spread}
                     <= {{(32-THR_BITS){1'b0}}, threshold});

    assign status.cnt_zero   = (ct == '0);
    assign status.expire_hit = ({1'b0, cur_pos} + 33'(len_reg)) <= {1'b0, pos_reg};
    assign status.back_hit   = cmd.sel ? (v_reg >= cur_val) : (v_reg <= cur_val);
    assign status.out_busy   = out_valid_reg && !out_ready;

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            v_reg    <= samp32[SAMPLE_BITS-1:0];
            last_reg <= last_sample;
            len_reg  <= len32[CW-1:0];
        end
        if (cmd.finish)
        begin
            start_reg <= pos_reg - 32'(len_reg) + 32'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            head_reg[0]   <= '0;
            head_reg[1]   <= '0;
            count_reg[0]  <= '0;
            count_reg[1]  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.latch)
            begin
                pos_reg <= pos_inc;
            end
            if (cmd.drop_head)
            begin
                head_reg[cmd.sel]  <= head_inc;
                count_reg[cmd.sel] <= ct - 1'b1;
            end
            if (cmd.drop_tail)
            begin
                count_reg[cmd.sel] <= ct - 1'b1;
            end
            if (cmd.push)
            begin
                // a full deque drops its front so the new entry lands at head+count
                if (ct == CW'(WINDOW_MAX))
                begin
                    head_reg[cmd.sel] <= head_inc;
                end
                else
                begin
                    count_reg[cmd.sel] <= ct + 1'b1;
                end
            end
            if (cmd.finish)
            begin
                out_valid_reg <= hit;
                if (last_reg)
                begin
                    pos_reg      <= '0;
                    head_reg[0]  <= '0;
                    head_reg[1]  <= '0;
                    count_reg[0] <= '0;
                    count_reg[1] <= '0;
                end
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign start_position = start_reg;
endmodule
`default_nettype wire

### hdl/sliding_window_silence_detector_unit.sv
// Top level of the sliding-window silence detector: APB registers, controller, datapath.
// Depends on swsd_pkg, swsd_ctrl, swsd_dp and swsd_ram.
//
// The block takes one unsigned sample per item and tracks the minimum and maximum of
// the last window_length samples with two monotonic deques kept in RAM (one entry per
// sample: value and 1-based position). Once a full window has been seen, each sample
// closes a window, and if max minus min is at most threshold the block returns one
// item holding that window's 1-based start position; otherwise it returns nothing.
// A sample with last_sample set is judged normally, then all stream state clears.
// A new item is accepted only once the last one is finished. Each deque in turn has
// entries expired from its front and popped from its back, each by a read step and a
// compare step, then the new sample is pushed; the finish step also waits while an
// earlier result is still held for out_ready. The pace is set by the single read port
// of each deque RAM, probed once per step.
// A finished result waits in an output register while the next item is accepted.
// Write window_length at address 0 and threshold at address 4, only while idle.
`default_nettype none
module sliding_window_silence_detector_unit
    import swsd_pkg::*;
#(
    parameter int WINDOW_MAX  = WINDOW_MAX_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [2:0]           paddr,
    input  wire logic [31:0]          pwdata,
    output logic      [31:0]          prdata,
    output logic                      pready,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [IN_BITS-1:0]   sample,
    input  wire logic                 last_sample,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [POS_BITS-1:0]       start_position
);
    logic [WLEN_BITS-1:0] wlen_reg;
    logic [THR_BITS-1:0]  thr_reg;
    logic                 cfg_wr;
    swsd_cmd_t            cmd;
    swsd_status_t         status;
    swsd_state_t          state;

    // register file: write in the access phase, read back combinationally
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wlen_reg <= WLEN_BITS'(1);
            thr_reg  <= '0;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == REG_WLEN)
            begin
                wlen_reg <= pwdata[WLEN_BITS-1:0];
            end
            else
            begin
                thr_reg <= pwdata[THR_BITS-1:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_THR) ? {{(32-THR_BITS){1'b0}}, thr_reg}
                                          : {{(32-WLEN_BITS){1'b0}}, wlen_reg};

    // sequence the deque steps for each accepted item
    swsd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd),
        .state    (state)
    );

    // hold the deques, the counter and the result register
    swsd_dp #(.WINDOW_MAX(WINDOW_MAX), .SAMPLE_BITS(SAMPLE_BITS)) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sample         (sample),
        .last_sample    (last_sample),
        .window_length  (wlen_reg),
        .threshold      (thr_reg),
        .out_ready      (out_ready),
        .status         (status),
        .out_valid      (out_valid),
        .start_position (start_position)
    );

    // an accepted item starts the expiry walk of the min deque
    a_accept_starts : assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state == ST_EXP_RD && !in_ready))
        else $error("accepted item did not start processing");

    // a result appears only right after the judging step
    a_result_source : assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state == ST_FINISH))
        else $error("result raised outside the judging step");

    // the judging step never overwrites a result that is still waiting
    a_no_overwrite : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |-> !cmd.finish)
        else $error("pending result overwritten");
endmodule
`default_nettype wire
